// ----- src/stream_search_replace_defines.svh -----
// Assertion macros shared by the checker of the stream search and replace block.
`ifndef STREAM_SEARCH_REPLACE_DEFINES_SVH
`define STREAM_SEARCH_REPLACE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SSR_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("stream_search_replace: check failed in the same cycle");

// The consequent must hold in the cycle after the antecedent.
`define SSR_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("stream_search_replace: check failed in the next cycle");

`endif

// ----- src/ssr_pkg.sv -----
// Types and constants shared by the stream search and replace block and its checker.
`default_nettype none

package ssr_pkg;

    localparam int MAX_PATTERN_DEF     = 16;
    localparam int MAX_REPLACEMENT_DEF = 16;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;
    localparam int LEN_W      = 5;

    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LOW        = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_HIGH       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LENGTH     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_REPLACEMENT_LOW    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_REPLACEMENT_HIGH   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_REPLACEMENT_LENGTH = 3'd5;

    typedef struct packed {
        logic [7:0] ch;
        logic       line_end;
    } text_t;

    typedef struct packed {
        logic [7:0] out_char;
        logic       out_valid;
        logic       end_of_line;
    } result_t;

endpackage

`default_nettype wire

// ----- src/stream_search_replace.sv -----
// Streaming search and replace: top level with the match sequencer and configuration registers.
// Flow: an accepted text beat is registered, then the sequencer compares it against the pattern
// and registers each result character; an empty pattern passes the character straight to the result.
// The block takes no new text beat before it is through with the last one: the text channel
// stalls while the sequencer works on a beat.
// Reset clears the configuration to zero, the partial match count and the result valid flag.
`default_nettype none

module stream_search_replace
    import ssr_pkg::*;
#(
    parameter int MAX_PATTERN     = MAX_PATTERN_DEF,
    parameter int MAX_REPLACEMENT = MAX_REPLACEMENT_DEF
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  text_valid,
    output logic                       text_stall,
    input  wire text_t                 text,
    output logic                       result_valid,
    input  wire logic                  result_stall,
    output result_t                    result,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int PL_W = $clog2(MAX_PATTERN + 1);
    localparam int RL_W = $clog2(MAX_REPLACEMENT + 1);
    localparam int PI_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
    localparam int RI_W = (MAX_REPLACEMENT > 1) ? $clog2(MAX_REPLACEMENT) : 1;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SCAN = 3'd1;
    localparam logic [2:0] S_PASS = 3'd2;
    localparam logic [2:0] S_REPL = 3'd3;
    localparam logic [2:0] S_FIN  = 3'd4;

    logic [7:0]       pat_reg [MAX_PATTERN];
    logic [7:0]       rep_reg [MAX_REPLACEMENT];
    logic [LEN_W-1:0] pat_len_reg;
    logic [LEN_W-1:0] rep_len_reg;

    logic [2:0]      state_reg, state_next;
    logic [PL_W-1:0] m_reg, m_next;
    logic [PL_W-1:0] j_reg, j_next;
    logic [PL_W-1:0] k_reg, k_next;
    logic [RL_W-1:0] r_reg, r_next;
    logic [PL_W-1:0] matched_reg, matched_next;
    logic            emitted_reg, emitted_next;
    logic            res_valid_reg, res_valid_next;
    result_t         res_reg, res_next;
    logic [7:0]      ch_reg, ch_next;
    logic            last_reg, last_next;

    logic [PL_W-1:0] pl;
    logic [RL_W-1:0] rl;
    logic [PL_W:0]   jk;
    logic [PL_W:0]   n_ext;
    logic [7:0]      buf_byte;
    logic [7:0]      pat_k;
    logic            out_free;
    logic            accept;

    assign pl = (pat_len_reg > LEN_W'(MAX_PATTERN)) ? PL_W'(MAX_PATTERN)
                                                     : pat_len_reg[PL_W-1:0];
    assign rl = (rep_len_reg > LEN_W'(MAX_REPLACEMENT)) ? RL_W'(MAX_REPLACEMENT)
                                                         : rep_len_reg[RL_W-1:0];

    assign jk       = {1'b0, j_reg} + {1'b0, k_reg};
    assign n_ext    = {1'b0, m_reg} + {{PL_W{1'b0}}, 1'b1};
    assign buf_byte = (jk == {1'b0, m_reg}) ? ch_reg : pat_reg[jk[PI_W-1:0]];
    assign pat_k    = pat_reg[k_reg[PI_W-1:0]];
    assign out_free = !res_valid_reg || !result_stall;
    assign accept   = text_valid && !text_stall;

    assign text_stall   = (state_reg != S_IDLE);
    assign result_valid = res_valid_reg;
    assign result       = res_reg;

    always_comb
    begin
        state_next     = state_reg;
        m_next         = m_reg;
        j_next         = j_reg;
        k_next         = k_reg;
        r_next         = r_reg;
        matched_next   = matched_reg;
        emitted_next   = emitted_reg;
        ch_next        = ch_reg;
        last_next      = last_reg;
        res_next       = res_reg;
        res_valid_next = res_valid_reg && result_stall;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    ch_next      = text.ch;
                    last_next    = text.line_end;
                    j_next       = '0;
                    k_next       = '0;
                    emitted_next = 1'b0;
                    matched_next = '0;
                    if (matched_reg >= pl)
                    begin
                        m_next = pl - PL_W'(1);
                    end
                    else
                    begin
                        m_next = matched_reg;
                    end
                    state_next = (pl == '0) ? S_PASS : S_SCAN;
                end
            end
            S_PASS:
            begin
                if (out_free)
                begin
                    res_next       = '{out_char: ch_reg, out_valid: 1'b1,
                                       end_of_line: last_reg};
                    res_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            S_SCAN:
            begin
                priority if ({1'b0, j_reg} == n_ext)
                begin
                    state_next = S_FIN;
                end
                else if ((jk < n_ext) && (k_reg < pl) && (buf_byte == pat_k))
                begin
                    k_next = k_reg + PL_W'(1);
                end
                else if (k_reg == pl)
                begin
                    r_next     = '0;
                    state_next = S_REPL;
                end
                else if ((jk == n_ext) && !last_reg)
                begin
                    matched_next = k_reg;
                    state_next   = S_IDLE;
                end
                else if (out_free)
                begin
                    // Once one character has matched, the first buffered one is pattern byte 0.
                    res_next       = '{out_char: (k_reg == '0) ? buf_byte : pat_reg[0],
                                       out_valid: 1'b1,
                                       end_of_line: last_reg && (j_reg == m_reg)};
                    res_valid_next = 1'b1;
                    emitted_next   = 1'b1;
                    j_next         = j_reg + PL_W'(1);
                    k_next         = '0;
                end
            end
            S_REPL:
            begin
                if (r_reg == rl)
                begin
                    state_next = S_FIN;
                end
                else if (out_free)
                begin
                    res_next       = '{out_char: rep_reg[r_reg[RI_W-1:0]], out_valid: 1'b1,
                                       end_of_line: last_reg && (r_reg == rl - RL_W'(1))};
                    res_valid_next = 1'b1;
                    emitted_next   = 1'b1;
                    r_next         = r_reg + RL_W'(1);
                end
            end
            S_FIN:
            begin
                if (last_reg && !emitted_reg)
                begin
                    if (out_free)
                    begin
                        res_next       = '{out_char: 8'd0, out_valid: 1'b0,
                                           end_of_line: 1'b1};
                        res_valid_next = 1'b1;
                        state_next     = S_IDLE;
                    end
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            m_reg         <= '0;
            j_reg         <= '0;
            k_reg         <= '0;
            r_reg         <= '0;
            matched_reg   <= '0;
            emitted_reg   <= 1'b0;
            last_reg      <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            m_reg         <= m_next;
            j_reg         <= j_next;
            k_reg         <= k_next;
            r_reg         <= r_next;
            matched_reg   <= matched_next;
            emitted_reg   <= emitted_next;
            last_reg      <= last_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ch_reg  <= ch_next;
        res_reg <= res_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_PATTERN; i++)
            begin
                pat_reg[i] <= 8'd0;
            end
            for (int i = 0; i < MAX_REPLACEMENT; i++)
            begin
                rep_reg[i] <= 8'd0;
            end
            pat_len_reg <= '0;
            rep_len_reg <= '0;
        end
        else if (cfg_we)
        begin
            for (int i = 0; i < MAX_PATTERN; i++)
            begin
                if ((i < 8) && (cfg_index == CFG_PATTERN_LOW))
                begin
                    pat_reg[i] <= cfg_data[8*(i%8) +: 8];
                end
                if ((i >= 8) && (cfg_index == CFG_PATTERN_HIGH))
                begin
                    pat_reg[i] <= cfg_data[8*(i%8) +: 8];
                end
            end
            for (int i = 0; i < MAX_REPLACEMENT; i++)
            begin
                if ((i < 8) && (cfg_index == CFG_REPLACEMENT_LOW))
                begin
                    rep_reg[i] <= cfg_data[8*(i%8) +: 8];
                end
                if ((i >= 8) && (cfg_index == CFG_REPLACEMENT_HIGH))
                begin
                    rep_reg[i] <= cfg_data[8*(i%8) +: 8];
                end
            end
            if (cfg_index == CFG_PATTERN_LENGTH)
            begin
                pat_len_reg <= cfg_data[LEN_W-1:0];
            end
            if (cfg_index == CFG_REPLACEMENT_LENGTH)
            begin
                rep_len_reg <= cfg_data[LEN_W-1:0];
            end
        end
    end

endmodule

`default_nettype wire

// ----- src/ssr_checker.sv -----
// Port checker for the stream search and replace block, bound to its top level.
`default_nettype none
`include "stream_search_replace_defines.svh"

module ssr_checker
    import ssr_pkg::*;
(
    input wire logic    clk,
    input wire logic    rst_n,
    input wire logic    text_valid,
    input wire logic    text_stall,
    input wire logic    result_valid,
    input wire logic    result_stall,
    input wire result_t result
);

    // A held result beat keeps its contents.
    `SSR_ASSERT_NEXT(a_result_hold, result_valid && result_stall, result_valid && $stable(result))

    // Accepting a beat always makes the text channel stall while the block works on it.
    `SSR_ASSERT_NEXT(a_busy_after_accept, text_valid && !text_stall, text_stall)

    // An empty-line marker is always the final beat of its line.
    `SSR_ASSERT_NOW(a_marker_ends_line, result_valid && !result.out_valid, result.end_of_line)

    // An empty-line marker carries a zero character.
    `SSR_ASSERT_NOW(a_marker_zero, result_valid && !result.out_valid, result.out_char == 8'd0)

endmodule

bind stream_search_replace ssr_checker u_ssr_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .text_valid   (text_valid),
    .text_stall   (text_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
);

`default_nettype wire
